// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: default sizes and operation codes.
package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TAG_BITS_DEF  = 32;
  localparam int PRIO_BITS_DEF = 16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

endpackage

// ===== rtl/spq_slot_ram.sv =====
// Slot store of the priority queue: one write port, one registered read port.
module spq_slot_ram #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int DATA_BITS = spq_pkg::TAG_BITS_DEF + spq_pkg::PRIO_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [DATA_BITS-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [DATA_BITS-1:0]         rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: a single slot memory walked by a small sequencer.
//
// Input channel (in_valid / in_stall): one transaction is an operation, insert
// (in_func = insert, with in_entry_tag and in_entry_priority) or remove head.
// Result channel (out_valid / out_stall): exactly one transaction per input,
// carrying success, the head entry after the operation, the count and flags.
// Entries are kept in ascending priority order in memory; the head sits at the
// top occupied slot. Equal priorities leave first-in first-out.
// A remove or a refused insert steps from acceptance through a head read and
// a head capture. An insert walks down from the free top slot, moving up each
// entry whose priority is not lower, with a read and a compare/write step per
// slot (slot zero is written in its read step), then reads and captures the
// head. The next transaction is taken in the cycle after the result loads.
// in_stall is high from acceptance until the result is loaded into the output
// register; a new transaction may be taken while that result still waits.
// If the receiver stalls, the result holds and the next finished result waits
// in the sequencer until the output register is free.
// Reset clears the count, the sequencer and out_valid; slot contents are not
// cleared; the contents of an unwritten slot are never used.
module sorted_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [TAG_BITS-1:0]          in_entry_tag,
  input  logic [PRIO_BITS-1:0]         in_entry_priority,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic [TAG_BITS-1:0]          out_head_tag,
  output logic [PRIO_BITS-1:0]         out_head_priority,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count,
  output logic                         out_is_empty,
  output logic                         out_is_full
);
  import spq_pkg::*;

  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int DATA_BITS = TAG_BITS + PRIO_BITS;
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_CMP   = 5'b00100,
    S_HREAD = 5'b01000,
    S_HCAP  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [ADDR_BITS-1:0]  pos_r, pos_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [PRIO_BITS-1:0]  prio_r, prio_nxt;
  logic                  ok_r, ok_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r;
  logic [TAG_BITS-1:0]   out_tag_r;
  logic [PRIO_BITS-1:0]  out_prio_r;
  logic [CNT_BITS-1:0]   out_cnt_r;
  logic                  out_load;

  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [DATA_BITS-1:0]  wr_data;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [DATA_BITS-1:0]  rd_data;
  logic [PRIO_BITS-1:0]  rd_prio;
  logic [CNT_BITS-1:0]   head_idx;

  assign rd_prio  = rd_data[PRIO_BITS-1:0];
  assign head_idx = count_r - CNT_BITS'(1);

  spq_slot_ram #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = {tag_r, prio_r};
    rd_addr   = head_idx[ADDR_BITS-1:0];
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tag_nxt  = in_entry_tag;
          prio_nxt = in_entry_priority;
          if (in_func == FUNC_REMOVE) begin
            ok_nxt = (count_r != '0);
            if (count_r != '0) begin
              count_nxt = count_r - CNT_BITS'(1);
            end
            state_nxt = S_HREAD;
          end else if (count_r == FULL_CNT) begin
            ok_nxt    = 1'b0;
            state_nxt = S_HREAD;
          end else begin
            ok_nxt    = 1'b1;
            pos_nxt   = count_r[ADDR_BITS-1:0];
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        rd_addr = pos_r - ADDR_BITS'(1);
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_BITS'(1);
          state_nxt = S_HREAD;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (rd_prio >= prio_r) begin
          // shift the slot below, whose priority is not lower, up and keep walking down
          wr_data   = rd_data;
          pos_nxt   = pos_r - ADDR_BITS'(1);
          state_nxt = S_RD;
        end else begin
          count_nxt = count_r + CNT_BITS'(1);
          state_nxt = S_HREAD;
        end
      end
      S_HREAD: begin
        state_nxt = S_HCAP;
      end
      S_HCAP: begin
        if (!(out_valid_r && out_stall)) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
    ok_r   <= ok_nxt;
    if (out_load) begin
      out_ok_r  <= ok_r;
      out_cnt_r <= count_r;
      if (count_r == '0) begin
        out_tag_r  <= '0;
        out_prio_r <= '0;
      end else begin
        out_tag_r  <= rd_data[DATA_BITS-1:PRIO_BITS];
        out_prio_r <= rd_data[PRIO_BITS-1:0];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_ok_r;
  assign out_head_tag      = out_tag_r;
  assign out_head_priority = out_prio_r;
  assign out_entry_count   = out_cnt_r;
  assign out_is_empty      = (out_cnt_r == '0);
  assign out_is_full       = (out_cnt_r == FULL_CNT);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("stored count exceeds depth");

  a_walk_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> pos_r != '0)
    else $error("compare step below slot zero");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_head_tag == '0 && out_head_priority == '0)
    else $error("empty queue reports a head entry");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

endmodule
